// ===== hdl/ipc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants for the incremental PI controller: command
// codes, register indexes, sequencer states and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package ipc_pkg;

  // Default datapath width and gain fraction bits.
  localparam int IPC_DATA_WIDTH     = 16;
  localparam int IPC_GAIN_FRAC_BITS = 8;

  // Fixed register field widths.
  localparam int GAIN_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int LIMIT_W  = 15;

  // The sample period is Q0.16, so ki*dt is shifted right by this amount.
  localparam int PERIOD_SHIFT = 16;

  // Multiplier A operand: kp + ki*dt is given two bits more than a gain.
  localparam int MUL_A_W = GAIN_W + 2;

  // Configuration bus.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Reset value of the output limit.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_INIT   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_MERGE  = 2'd3
  } ipc_cmd_t;

  typedef enum logic [1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_INTEG_GAIN    = 2'd1,
    REG_SAMPLE_PERIOD = 2'd2,
    REG_OUTPUT_LIMIT  = 2'd3
  } ipc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KID,
    ST_GAIN,
    ST_ADD_G,
    ST_SUB_P,
    ST_FIN
  } ipc_state_t;

endpackage

// ===== hdl/ipc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_mul
// Shared signed multiplier with a registered product. The sequencer in the
// top level feeds it one operand pair per cycle when enabled.
// ----------------------------------------------------------------------------
module ipc_mul #(
  parameter int B_WIDTH = ipc_pkg::IPC_DATA_WIDTH + 1
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [ipc_pkg::MUL_A_W-1:0]      a,
  input  logic signed [B_WIDTH-1:0]               b,
  output logic signed [ipc_pkg::MUL_A_W+B_WIDTH-1:0] p_r
);

  localparam int PW = ipc_pkg::MUL_A_W + B_WIDTH;

  logic signed [PW-1:0] p_nxt;

  // Full-width signed product.
  always_comb begin
    p_nxt = PW'(a) * PW'(b);
  end

  // Product register, held while the unit is not in use.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

// ===== hdl/incremental_pi_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pi_controller_top
// Velocity-form PI controller with a symmetric output clamp, built around
// one shared multiplier driven by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Word
//  in_*      input      in_valid / in_ready    command, setpoint, measurement,
//                                              preset value
//  out_*     output     out_valid / out_ready  control output
//  APB       input      psel, penable, pwrite  four control registers
//
//  An update steps the sequencer through ST_KID, ST_GAIN, ST_ADD_G, ST_SUB_P
//  and ST_FIN (ST_GAIN, ST_ADD_G, ST_FIN on the first update after reset or
//  init; init, clear and merge go straight to ST_FIN), as the one multiplier
//  forms ki*dt, (kp + ki*dt)*e and kp*e_prev one after the other. in_ready
//  returns as the result is loaded into the output register, so no new word
//  is taken while one is in work. A stalled output holds the sequencer in its final state.
//  Reset is synchronous, active low, and clears the held output and error.
// ----------------------------------------------------------------------------
module incremental_pi_controller_top #(
  parameter int DATA_WIDTH     = ipc_pkg::IPC_DATA_WIDTH,
  parameter int GAIN_FRAC_BITS = ipc_pkg::IPC_GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic signed [DATA_WIDTH-1:0]        in_setpoint,
  input  logic signed [DATA_WIDTH-1:0]        in_measurement,
  input  logic signed [DATA_WIDTH-1:0]        in_preset_value,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        out_control_output,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipc_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [ipc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int GW   = ipc_pkg::GAIN_W;
  localparam int TW   = ipc_pkg::PERIOD_W;
  localparam int LW   = ipc_pkg::LIMIT_W;
  localparam int CDW  = ipc_pkg::CFG_DATA_W;
  localparam int AW_A = ipc_pkg::MUL_A_W;
  localparam int EW   = DATA_WIDTH + 1;
  localparam int BW   = (EW > TW + 1) ? EW : TW + 1;
  localparam int PW   = AW_A + BW;
  localparam int ACW  = DATA_WIDTH + 20;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  logic signed [GW-1:0] prop_gain_r;
  logic signed [GW-1:0] integ_gain_r;
  logic        [TW-1:0] sample_period_r;
  logic        [LW-1:0] output_limit_r;
  logic                 cfg_wr;
  ipc_pkg::ipc_reg_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ipc_pkg::ipc_reg_t'(paddr[3:2]);

  // Register writes happen on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= '0;
      integ_gain_r    <= '0;
      sample_period_r <= '0;
      output_limit_r  <= ipc_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ipc_pkg::REG_PROP_GAIN:     prop_gain_r     <= pwdata[GW-1:0];
        ipc_pkg::REG_INTEG_GAIN:    integ_gain_r    <= pwdata[GW-1:0];
        ipc_pkg::REG_SAMPLE_PERIOD: sample_period_r <= pwdata[TW-1:0];
        ipc_pkg::REG_OUTPUT_LIMIT:  output_limit_r  <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      ipc_pkg::REG_PROP_GAIN:     prdata = {{(CDW-GW){1'b0}}, prop_gain_r};
      ipc_pkg::REG_INTEG_GAIN:    prdata = {{(CDW-GW){1'b0}}, integ_gain_r};
      ipc_pkg::REG_SAMPLE_PERIOD: prdata = {{(CDW-TW){1'b0}}, sample_period_r};
      ipc_pkg::REG_OUTPUT_LIMIT:  prdata = {{(CDW-LW){1'b0}}, output_limit_r};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller state and sequencer registers
  // --------------------------------------------------------------------------
  ipc_pkg::ipc_state_t         state_r, state_nxt;
  ipc_pkg::ipc_cmd_t           cmd_r, cmd_nxt;
  logic signed [EW-1:0]        err_r, err_nxt;
  logic signed [ACW-1:0]       acc_r, acc_nxt;
  logic signed [DATA_WIDTH-1:0] last_out_r, last_out_nxt;
  logic signed [EW-1:0]        last_err_r, last_err_nxt;
  logic                        first_r, first_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_data_r, out_data_nxt;

  // Shared multiplier operands.
  logic                        mul_en;
  logic signed [AW_A-1:0]      mul_a;
  logic signed [BW-1:0]        mul_b;
  logic signed [PW-1:0]        prod_r;

  ipc_mul #(
    .B_WIDTH (BW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // Product scaled back from the gain format, and the combined gain.
  logic signed [PW-1:0]   prod_frac;
  logic signed [PW-1:0]   prod_kid;
  logic signed [ACW-1:0]  term;
  logic signed [AW_A-1:0] gain_sum;
  logic                   in_acc;
  logic                   out_load;

  assign prod_frac = prod_r >>> GAIN_FRAC_BITS;
  assign prod_kid  = prod_r >>> ipc_pkg::PERIOD_SHIFT;
  assign term      = ACW'(prod_frac);
  assign gain_sum  = AW_A'(prop_gain_r) + AW_A'(prod_kid);

  assign in_ready  = (state_r == ipc_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state_r == ipc_pkg::ST_FIN) && (!out_valid_r || out_ready);

  // Clamp of the update sum: first to the limit, then to the data range.
  logic signed [ACW-1:0] lim_pos, lim_neg, dmax, dmin, clamp1, clamp2;

  assign lim_pos = ACW'(signed'({1'b0, output_limit_r}));
  assign lim_neg = -lim_pos;
  assign dmax    = ACW'(signed'({1'b0, {(DATA_WIDTH-1){1'b1}}}));
  assign dmin    = -dmax - ACW'(1);

  always_comb begin
    if (acc_r > lim_pos) begin
      clamp1 = lim_pos;
    end else if (acc_r < lim_neg) begin
      clamp1 = lim_neg;
    end else begin
      clamp1 = acc_r;
    end
    if (clamp1 > dmax) begin
      clamp2 = dmax;
    end else if (clamp1 < dmin) begin
      clamp2 = dmin;
    end else begin
      clamp2 = clamp1;
    end
  end

  // Sequencer: next state, multiplier control and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    last_out_nxt  = last_out_r;
    last_err_nxt  = last_err_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_en        = 1'b0;
    mul_a         = AW_A'(prop_gain_r);
    mul_b         = BW'(err_r);

    // The consumer takes the waiting word.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ipc_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt = ipc_pkg::ipc_cmd_t'(in_command);
          err_nxt = EW'(in_setpoint) - EW'(in_measurement);
          case (ipc_pkg::ipc_cmd_t'(in_command))
            ipc_pkg::CMD_UPDATE: begin
              acc_nxt   = ACW'(last_out_r);
              state_nxt = first_r ? ipc_pkg::ST_GAIN : ipc_pkg::ST_KID;
            end
            ipc_pkg::CMD_CLEAR: begin
              acc_nxt   = '0;
              state_nxt = ipc_pkg::ST_FIN;
            end
            default: begin
              acc_nxt   = ACW'(in_preset_value);
              state_nxt = ipc_pkg::ST_FIN;
            end
          endcase
        end
      end

      // ki * dt
      ipc_pkg::ST_KID: begin
        mul_en    = 1'b1;
        mul_a     = AW_A'(integ_gain_r);
        mul_b     = BW'(signed'({1'b0, sample_period_r}));
        state_nxt = ipc_pkg::ST_GAIN;
      end

      // (kp + ki*dt) * e, or kp * e on the first update.
      ipc_pkg::ST_GAIN: begin
        mul_en    = 1'b1;
        mul_a     = first_r ? AW_A'(prop_gain_r) : gain_sum;
        mul_b     = BW'(err_r);
        state_nxt = ipc_pkg::ST_ADD_G;
      end

      // Add the gain term and, unless this is the first update, start kp * e_prev.
      ipc_pkg::ST_ADD_G: begin
        acc_nxt   = acc_r + term;
        mul_en    = !first_r;
        mul_a     = AW_A'(prop_gain_r);
        mul_b     = BW'(last_err_r);
        state_nxt = first_r ? ipc_pkg::ST_FIN : ipc_pkg::ST_SUB_P;
      end

      // Subtract the previous proportional term.
      ipc_pkg::ST_SUB_P: begin
        acc_nxt   = acc_r - term;
        state_nxt = ipc_pkg::ST_FIN;
      end

      // Load the output word and commit the controller state.
      ipc_pkg::ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ipc_pkg::ST_IDLE;
          case (cmd_r)
            ipc_pkg::CMD_UPDATE: begin
              out_data_nxt = clamp2[DATA_WIDTH-1:0];
              last_out_nxt = clamp2[DATA_WIDTH-1:0];
              last_err_nxt = err_r;
              first_nxt    = 1'b0;
            end
            ipc_pkg::CMD_INIT: begin
              out_data_nxt = acc_r[DATA_WIDTH-1:0];
              last_out_nxt = acc_r[DATA_WIDTH-1:0];
              first_nxt    = 1'b1;
            end
            ipc_pkg::CMD_CLEAR: begin
              out_data_nxt = '0;
              last_out_nxt = '0;
              last_err_nxt = '0;
              first_nxt    = 1'b0;
            end
            default: begin
              out_data_nxt = acc_r[DATA_WIDTH-1:0];
              last_out_nxt = acc_r[DATA_WIDTH-1:0];
            end
          endcase
        end
      end

      default: begin
        state_nxt = ipc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, initialised by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_out_r  <= '0;
      last_err_r  <= '0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_out_r  <= last_out_nxt;
      last_err_r  <= last_err_nxt;
      first_r     <= first_nxt;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    err_r      <= err_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_control_output = out_data_r;

endmodule

// ===== hdl/ipc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks on the PI controller's handshakes, attached to the top
// level by a bind statement.
// ----------------------------------------------------------------------------
module ipc_checker #(
  parameter int DATA_WIDTH = ipc_pkg::IPC_DATA_WIDTH
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_control_output,
  input logic                  pready
);

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_control_output))
    else $error("ipc: stalled output word changed or dropped");

  // Only one word is in work at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ipc: input accepted while a word is in work");

  // No result appears in the cycle right after an accept with an empty output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("ipc: result appeared too early");

  // Reset empties the output register.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("ipc: output valid after reset");

  // The configuration port never waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("ipc: pready low");

endmodule

bind incremental_pi_controller_top ipc_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_ipc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_control_output (out_control_output),
  .pready             (pready)
);

// ===== test/tb_incremental_pi_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_incremental_pi_controller_top
// Self-checking bench for the velocity-form PI controller. A short table of
// directed words runs first, then random words under several gain and limit
// settings. Each accepted word is run through a local model of the
// controller, and every output word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_incremental_pi_controller_top;

  localparam int  CLK_HALF      = 5;
  localparam int  DW            = ipc_pkg::IPC_DATA_WIDTH;
  localparam int  FRAC          = ipc_pkg::IPC_GAIN_FRAC_BITS;
  localparam int  DRAIN_CYCLES  = 8;
  localparam int  WATCHDOG_MAX  = 4000;
  localparam int  LONG_HOLD     = 400;
  localparam int  PHASES        = 8;
  localparam int  RANDOM_WORDS  = 245;
  localparam int  TABLE_ROWS    = 21;
  localparam longint DATA_MAX   = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint DATA_MIN   = -DATA_MAX - 1;

  // One set of control registers.
  typedef struct packed {
    logic [ipc_pkg::GAIN_W-1:0]   kp;
    logic [ipc_pkg::GAIN_W-1:0]   ki;
    logic [ipc_pkg::PERIOD_W-1:0] dt;
    logic [ipc_pkg::LIMIT_W-1:0]  lim;
  } gain_set_t;

  // One directed word; want is used only where typed is set.
  typedef struct packed {
    ipc_pkg::ipc_cmd_t cmd;
    logic [DW-1:0]     sp;
    logic [DW-1:0]     ms;
    logic [DW-1:0]     pre;
    logic              typed;
    logic [DW-1:0]     want;
  } step_row_t;

  // Directed table, run with kp = 1.0, ki = -128.0, dt = 1 - 2^-16, limit 1000.
  localparam step_row_t DIRECTED [TABLE_ROWS] = '{
    '{ipc_pkg::CMD_UPDATE, 16'd1000, 16'd0,    16'd0,    1'b1, 16'd1000},
    '{ipc_pkg::CMD_MERGE,  16'd0,    16'd0,    16'h7FFF, 1'b1, 16'h7FFF},
    '{ipc_pkg::CMD_MERGE,  16'd0,    16'd0,    16'h8000, 1'b1, 16'h8000},
    '{ipc_pkg::CMD_CLEAR,  16'd0,    16'd0,    16'd0,    1'b1, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'h7FFF, 16'h8000, 16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'h8000, 16'h7FFF, 16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_INIT,   16'd0,    16'd0,    16'd30000, 1'b1, 16'd30000},
    '{ipc_pkg::CMD_UPDATE, 16'd0,    16'd0,    16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'd100,  16'd50,   16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_INIT,   16'h7FFF, 16'h8000, 16'h8000, 1'b1, 16'h8000},
    '{ipc_pkg::CMD_UPDATE, 16'd5,    16'd5,    16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_CLEAR,  16'd123,  16'hFFF9, 16'd555,  1'b1, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'h8000, 16'h8000, 16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_MERGE,  16'd0,    16'd0,    16'd0,    1'b1, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'd1,    16'd0,    16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'hFFFF, 16'd0,    16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_INIT,   16'd0,    16'd0,    16'd0,    1'b1, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'h7FFF, 16'd0,    16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_UPDATE, 16'h8000, 16'd0,    16'd0,    1'b0, 16'd0},
    '{ipc_pkg::CMD_MERGE,  16'h5555, 16'hAAAA, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ipc_pkg::CMD_UPDATE, 16'h5555, 16'hAAAA, 16'h1234, 1'b0, 16'd0}
  };

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            in_valid        = 1'b0;
  logic                            in_ready;
  logic [1:0]                      in_command      = ipc_pkg::CMD_UPDATE;
  logic signed [DW-1:0]            in_setpoint     = '0;
  logic signed [DW-1:0]            in_measurement  = '0;
  logic signed [DW-1:0]            in_preset_value = '0;
  logic                            out_valid;
  logic                            out_ready       = 1'b0;
  logic signed [DW-1:0]            out_control_output;
  logic                            psel            = 1'b0;
  logic                            penable         = 1'b0;
  logic                            pwrite          = 1'b0;
  logic [ipc_pkg::CFG_ADDR_W-1:0]  paddr           = '0;
  logic [ipc_pkg::CFG_DATA_W-1:0]  pwdata          = '0;
  logic [ipc_pkg::CFG_DATA_W-1:0]  prdata;
  logic                            pready;

  // Local copy of the controller registers and state.
  logic signed [ipc_pkg::GAIN_W-1:0] cfg_prop_gain     = '0;
  logic signed [ipc_pkg::GAIN_W-1:0] cfg_integ_gain    = '0;
  logic [ipc_pkg::PERIOD_W-1:0]      cfg_sample_period = '0;
  logic [ipc_pkg::LIMIT_W-1:0]       cfg_output_limit  = ipc_pkg::LIMIT_RESET;
  logic signed [DW-1:0]              held_output       = '0;
  logic signed [DW:0]                held_error        = '0;
  logic                              first_armed       = 1'b1;

  logic [DW-1:0] expected_outputs [$];
  int            mismatches    = 0;
  int            words_checked = 0;
  int            idle_cycles   = 0;

  incremental_pi_controller_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_setpoint        (in_setpoint),
    .in_measurement     (in_measurement),
    .in_preset_value    (in_preset_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_control_output (out_control_output),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Advance the local controller by one word and return the held output.
  function automatic logic [DW-1:0] pi_controller_next(ipc_pkg::ipc_cmd_t cmd,
                                                       logic signed [DW-1:0] sp,
                                                       logic signed [DW-1:0] ms,
                                                       logic signed [DW-1:0] pre);
    longint kp, ki, kid, err, u, lim;
    kp  = longint'(cfg_prop_gain);
    ki  = longint'(cfg_integ_gain);
    lim = longint'(cfg_output_limit);
    case (cmd)
      ipc_pkg::CMD_UPDATE: begin
        err = longint'(sp) - longint'(ms);
        if (first_armed) begin
          first_armed = 1'b0;
          u = longint'(held_output) + ((kp * err) >>> FRAC);
        end else begin
          kid = (ki * longint'(cfg_sample_period)) >>> ipc_pkg::PERIOD_SHIFT;
          u = longint'(held_output) + (((kp + kid) * err) >>> FRAC)
              - ((kp * longint'(held_error)) >>> FRAC);
        end
        // Symmetric limit first, then the data range.
        if (u > lim) u = lim;
        if (u < -lim) u = -lim;
        if (u > DATA_MAX) u = DATA_MAX;
        if (u < DATA_MIN) u = DATA_MIN;
        held_output = u[DW-1:0];
        held_error  = err[DW:0];
      end
      ipc_pkg::CMD_INIT: begin
        held_output = pre;
        first_armed = 1'b1;
      end
      ipc_pkg::CMD_CLEAR: begin
        held_output = '0;
        held_error  = '0;
        first_armed = 1'b0;
      end
      default: begin
        held_output = pre;
      end
    endcase
    return held_output;
  endfunction

  // Write one register: setup cycle, then access cycle, then an idle pause.
  task automatic reg_write(ipc_pkg::ipc_reg_t idx, logic [ipc_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ipc_pkg::REG_PROP_GAIN:     cfg_prop_gain     = data[ipc_pkg::GAIN_W-1:0];
      ipc_pkg::REG_INTEG_GAIN:    cfg_integ_gain    = data[ipc_pkg::GAIN_W-1:0];
      ipc_pkg::REG_SAMPLE_PERIOD: cfg_sample_period = data[ipc_pkg::PERIOD_W-1:0];
      default:                    cfg_output_limit  = data[ipc_pkg::LIMIT_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic load_gains(gain_set_t g);
    reg_write(ipc_pkg::REG_PROP_GAIN, {16'b0, g.kp});
    reg_write(ipc_pkg::REG_INTEG_GAIN, {16'b0, g.ki});
    reg_write(ipc_pkg::REG_SAMPLE_PERIOD, {16'b0, g.dt});
    reg_write(ipc_pkg::REG_OUTPUT_LIMIT, {17'b0, g.lim});
  endtask

  // Offer one word, hold it until taken, then record the expected output.
  task automatic offer_word(ipc_pkg::ipc_cmd_t cmd, logic [DW-1:0] sp,
                            logic [DW-1:0] ms, logic [DW-1:0] pre, logic typed,
                            logic [DW-1:0] want);
    logic [DW-1:0] predicted;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_setpoint     <= sp;
    in_measurement  <= ms;
    in_preset_value <= pre;
    do @(posedge clk); while (!in_ready);
    predicted = pi_controller_next(cmd, sp, ms, pre);
    expected_outputs.push_back(typed ? want : predicted);
  endtask

  // Stop offering and let every outstanding output word come back.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Main stimulus: directed table, then random phases.
  initial begin : stimulus
    gain_set_t         phase_gains [PHASES];
    step_row_t         row;
    ipc_pkg::ipc_cmd_t cmd;
    logic [DW-1:0]     sp, ms, pre;
    int                pick, burst_left, gap;

    phase_gains[0] = '{16'h0100, 16'h8000, 16'hFFFF, 15'd1000};
    phase_gains[1] = '{16'h0000, 16'h0000, 16'h0000, 15'd0};
    phase_gains[2] = '{16'h7FFF, 16'h7FFF, 16'hFFFF, 15'h7FFF};
    phase_gains[3] = '{16'h8000, 16'h8000, 16'hFFFF, 15'h7FFF};
    phase_gains[4] = '{16'h0180, 16'h0040, 16'd655, 15'd20000};
    phase_gains[5] = '{16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom)};
    phase_gains[6] = '{16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom)};
    phase_gains[7] = '{16'hFF00, 16'h7FFF, 16'h0001, 15'($urandom_range(1, 32767))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      load_gains(phase_gains[p]);
      if (p == 0) begin
        for (int r = 0; r < TABLE_ROWS; r++) begin
          row = DIRECTED[r];
          offer_word(row.cmd, row.sp, row.ms, row.pre, row.typed, row.want);
        end
      end else begin
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
          // Bursts of words with random gaps; some bursts run back to back.
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
              in_valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
          burst_left--;

          // Mostly updates, with presets and clears mixed in.
          pick = $urandom_range(0, 99);
          if (pick < 72)      cmd = ipc_pkg::CMD_UPDATE;
          else if (pick < 82) cmd = ipc_pkg::CMD_MERGE;
          else if (pick < 92) cmd = ipc_pkg::CMD_INIT;
          else                cmd = ipc_pkg::CMD_CLEAR;

          // Errors are small around a random setpoint in half the words, else random or extreme.
          sp = DW'($urandom);
          case ($urandom_range(0, 3))
            0: ms = DW'($urandom);
            3: begin
              sp = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
              ms = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
            end
            default: ms = sp - DW'($urandom_range(0, 512)) + DW'(256);
          endcase
          pre = ($urandom_range(0, 1) == 1) ? DW'($urandom)
                                            : DW'($urandom_range(0, 2000)) - DW'(1000);
          offer_word(cmd, sp, ms, pre, 1'b0, '0);
        end
      end
      drain_outputs();
    end

    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Output side: stall pattern that changes mode now and then, plus two long
  // hold-offs so that the block fills up and stops taking input words.
  initial begin : rx_stall
    int rx_mode, mode_left, holds_done, tick;
    rx_mode    = 0;
    mode_left  = 0;
    holds_done = 0;
    tick       = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (holds_done < 2 && words_checked >= (holds_done + 1) * 600) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 9) < 3);
          default: out_ready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  // Compare each output word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_checked <= words_checked + 1;
      if (expected_outputs.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) begin
          $display("unexpected output word: control_output %0d", out_control_output);
        end
      end else begin
        if (out_control_output !== expected_outputs[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("control_output mismatch: expected %0d, got %0d",
                     $signed(expected_outputs[0]), out_control_output);
          end
        end
        void'(expected_outputs.pop_front());
      end
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
